// ----- hw/rtl/cnmp_pkg.sv -----
// ----------------------------------------------------------------------------
// cnmp_pkg: shared constants and types for the Catalan number cache
// Field widths, bus widths, the prime modulus and the Barrett constant.
// ----------------------------------------------------------------------------
package cnmp_pkg;

   localparam int NUM_W       = 10;
   localparam int WAYS_W      = 30;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 32;

   localparam int DEFAULT_TABLE_DEPTH = 512;

   // Modulus, and floor(2^60 / PRIME) for Barrett reduction with k = 30.
   localparam logic [WAYS_W-1:0] PRIME      = 30'd1000000007;
   localparam logic [30:0]       BARRETT_MU = 31'd1152921496;

   typedef logic [WAYS_W-1:0] ways_type;

endpackage

// ----- hw/rtl/catalan_number_mod_prime.sv -----
// ----------------------------------------------------------------------------
// catalan_number_mod_prime: non-crossing handshake count modulo 1000000007
// Answers Catalan(n/2) mod 1000000007 for a count of n people, out of a
// table cache that is filled bottom-up by a pipelined multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage: a transfer on the req_ channel carries the head count in
// req_tdata[9:0]. Exactly one transfer follows on the rsp_ channel with ways
// in rsp_tdata[29:0]; it is zero for an odd count or a half count that is
// beyond the table. Items are handled one at a time, in order.
// Sequence: a cached answer passes through the check, read and done states
// before rsp_tvalid rises; an odd count or a half count beyond the table
// goes from idle straight to the done state. Building entry m (m >= 1) runs
// a check state, then issues m products, one product per cycle, through the
// dual-read table memory, then lets the multiply and Barrett reduction
// pipeline drain and writes the sum back.
// Reset clears the fill count, so the table is rebuilt lazily from entry 0;
// the memory itself is not cleared since entries are only read after they
// have been written. The result sits in an output register: while the
// receiver stalls the block still takes the next request and works on it,
// and only waits once that next result is ready to go out.
// ----------------------------------------------------------------------------
module catalan_number_mod_prime #(
   parameter int TABLE_DEPTH = cnmp_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cnmp_pkg::REQ_TDATA_W-1:0] req_tdata,   // [9:0] head_count
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cnmp_pkg::RSP_TDATA_W-1:0] rsp_tdata    // [29:0] ways
);
   import cnmp_pkg::*;

   // Table address width, fill count width and half-count width. Compares
   // between count and half count are done at the sum of both widths.
   localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int KW   = NUM_W - 1;
   localparam int CMPW = CW + KW;
   localparam logic [CMPW-1:0] DEPTH_C = CMPW'(TABLE_DEPTH);
   localparam int PIPE_N = 6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_ISSUE,
      S_DRAIN,
      S_READ,
      S_DONE
   } state_type;

   state_type state_ff;

   // Table memory: two read ports with registered data, one write port.
   ways_type table_mem [TABLE_DEPTH];
   ways_type rd_a_ff, rd_b_ff;
   logic     rd_en_in, wr_en_in;
   logic [AW-1:0] rd_addr_a_in, rd_addr_b_in, wr_addr_in;
   ways_type wr_data_in;

   // Request context and fill sequencer.
   logic [KW-1:0] k_ff;
   logic          zero_ff;
   logic [CW-1:0] valid_ff;
   logic [AW-1:0] i_ff;
   logic [CMPW-1:0] k_ext, valid_ext;
   logic [AW-1:0]   m_cur;
   logic            need_fill;

   // Product pipeline.
   logic [PIPE_N-1:0] v_ff;
   logic              issue_in;
   logic [59:0]       prod_ff;
   logic [61:0]       q2_ff;
   logic [31:0]       plo1_ff, plo2_ff, t_ff, r_ff;
   ways_type          red_ff, acc_ff;
   logic [31:0]       red_in;
   logic [30:0]       acc_sum_in;

   logic              rsp_tvalid_ff;
   ways_type          rsp_ways_ff;

   assign k_ext     = {{CW{1'b0}}, k_ff};
   assign valid_ext = {{KW{1'b0}}, valid_ff};
   assign m_cur     = valid_ff[AW-1:0];
   assign need_fill = (valid_ext <= k_ext);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-WAYS_W){1'b0}}, rsp_ways_ff};

   // Memory port control.
   always_comb begin
      issue_in     = (state_ff == S_ISSUE);
      rd_en_in     = 1'b0;
      rd_addr_a_in = i_ff;
      rd_addr_b_in = m_cur - AW'(1) - i_ff;
      wr_en_in     = 1'b0;
      wr_addr_in   = m_cur;
      wr_data_in   = acc_ff;
      if (state_ff == S_ISSUE) begin
         rd_en_in = 1'b1;
      end else if (state_ff == S_CHECK && !need_fill) begin
         // The table already covers the request: fetch the answer.
         rd_en_in     = 1'b1;
         rd_addr_a_in = k_ext[AW-1:0];
      end
      if (state_ff == S_CHECK && need_fill && valid_ff == '0) begin
         // Catalan(0) is seeded directly.
         wr_en_in   = 1'b1;
         wr_data_in = ways_type'(1);
      end else if (state_ff == S_DRAIN && v_ff == '0) begin
         wr_en_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en_in) begin
         rd_a_ff <= table_mem[rd_addr_a_in];
         rd_b_ff <= table_mem[rd_addr_b_in];
      end
      if (wr_en_in) begin
         table_mem[wr_addr_in] <= wr_data_in;
      end
   end

   // Multiply and Barrett reduction. The product is below PRIME^2 < 2^60,
   // so the quotient estimate is short by at most two and the remainder
   // fits in 32 bits.
   always_comb begin
      if (r_ff >= {PRIME, 1'b0}) begin
         red_in = r_ff - {1'b0, PRIME, 1'b0};
      end else if (r_ff >= {2'b00, PRIME}) begin
         red_in = r_ff - {2'b00, PRIME};
      end else begin
         red_in = r_ff;
      end
      acc_sum_in = {1'b0, acc_ff} + {1'b0, red_ff};
   end

   always_ff @(posedge clock) begin
      prod_ff <= {30'b0, rd_a_ff} * {30'b0, rd_b_ff};
      q2_ff   <= {31'b0, prod_ff[59:29]} * {31'b0, BARRETT_MU};
      plo1_ff <= prod_ff[31:0];
      t_ff    <= {1'b0, q2_ff[61:31]} * {2'b00, PRIME};
      plo2_ff <= plo1_ff;
      r_ff    <= plo2_ff - t_ff;
      red_ff  <= red_in[WAYS_W-1:0];
   end

   // Sequencer, accumulator and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         v_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         v_ff <= {v_ff[PIPE_N-2:0], issue_in};
         if (v_ff[PIPE_N-1]) begin
            if (acc_sum_in >= {1'b0, PRIME}) begin
               acc_ff <= WAYS_W'(acc_sum_in - {1'b0, PRIME});
            end else begin
               acc_ff <= acc_sum_in[WAYS_W-1:0];
            end
         end
         // In S_DONE the output register is handled by the state itself.
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  k_ff     <= req_tdata[NUM_W-1:1];
                  zero_ff  <= req_tdata[0] ||
                              ({{CW{1'b0}}, req_tdata[NUM_W-1:1]} >= DEPTH_C);
                  state_ff <= (req_tdata[0] ||
                              ({{CW{1'b0}}, req_tdata[NUM_W-1:1]} >= DEPTH_C))
                              ? S_DONE : S_CHECK;
               end
            end
            S_CHECK: begin
               if (!need_fill) begin
                  state_ff <= S_READ;
               end else if (valid_ff == '0) begin
                  valid_ff <= valid_ff + CW'(1);
               end else begin
                  i_ff     <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_ISSUE;
               end
            end
            S_ISSUE: begin
               if (i_ff == m_cur - AW'(1)) begin
                  state_ff <= S_DRAIN;
               end else begin
                  i_ff <= i_ff + AW'(1);
               end
            end
            S_DRAIN: begin
               // The sum is complete once the pipeline is empty.
               if (v_ff == '0) begin
                  valid_ff <= valid_ff + CW'(1);
                  state_ff <= S_CHECK;
               end
            end
            S_READ: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_ways_ff   <= zero_ff ? '0 : rd_a_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
